/* design/cdq_pkg.sv */
package cdq_pkg;

    localparam int WORD_W        = 32;
    localparam int FILL_W        = 8;
    localparam int DEPTH_DEFAULT = 128;

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [WORD_W-1:0]  push_value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  pop_value;
        logic [FILL_W-1:0]         fill_level;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic load_rd;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic rd_pend;
    } sts_t;

endpackage

/* design/circular_deque.sv */
// channel  | ports                        | beat
// ---------+------------------------------+----------------------------------
// request  | s_valid s_ready s_data       | mode, push_value
// result   | m_valid m_ready m_data       | status, pop_value, fill_level
//
// One request at a time: a push or a rejected request executes after accept once
// the result slot is free, and its result is registered; a pop that is not rejected
// then passes through a read state for the registered read port of the ring RAM.
// A new request is taken only when the last one has left execution.
// aresetn (synchronous, active low) empties the queue; the RAM is not cleared.
// A stalled result holds its request in execution until m_ready frees the slot.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cdq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cdq_pkg::out_item_t m_data
);

    cdq_pkg::cmd_t cmd;
    cdq_pkg::sts_t sts;

    cdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* design/cdq_ram.sv */
module cdq_ram #(
    parameter int WIDTH = cdq_pkg::WORD_W,
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/cdq_ctrl.sv */
module cdq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cdq_pkg::sts_t sts,
    output cdq_pkg::cmd_t cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cdq_pkg::ST_EXEC;
                end
            end
            cdq_pkg::ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = sts.rd_pend ? cdq_pkg::ST_READ : cdq_pkg::ST_IDLE;
                end
            end
            cdq_pkg::ST_READ: begin
                if (sts.out_free) begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default: state_next = cdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.take    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load_rd = 1'b0;
        unique case (state_reg)
            cdq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            cdq_pkg::ST_EXEC: begin
                cmd.exec = sts.out_free;
            end
            cdq_pkg::ST_READ: begin
                cmd.load_rd = sts.out_free;
            end
            default: ;
        endcase
    end

    // a popped word must be collected before the next beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && sts.rd_pend |=> !s_ready)
        else $error("next beat accepted while a pop read is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.exec, cmd.load_rd}))
        else $error("controller issued more than one command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> state_reg == cdq_pkg::ST_EXEC && !s_ready)
        else $error("accepted beat not held for execution");

endmodule

/* design/cdq_dp.sv */
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cdq_pkg::in_item_t s_data,
    input  cdq_pkg::cmd_t     cmd,
    output cdq_pkg::sts_t     sts,
    output logic              m_valid,
    input  logic              m_ready,
    output cdq_pkg::out_item_t m_data
);

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cdq_pkg::in_item_t  item_reg;
    cdq_pkg::out_item_t res_reg;
    cdq_pkg::out_item_t res_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [IW-1:0] head_up, head_dn, tail_up, tail_dn;
    logic          is_full, cnt_zero, is_push, reject;
    cdq_pkg::status_t stat;

    logic              ram_wr_en, ram_rd_en;
    logic [IW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [cdq_pkg::WORD_W-1:0] ram_rd_data;
    logic [CW+cdq_pkg::FILL_W-1:0] fill_ext_next, fill_ext_cur;

    assign head_up  = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
    assign head_dn  = (head_reg == '0) ? LAST_IDX : head_reg - IW'(1);
    assign tail_up  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
    assign tail_dn  = (tail_reg == '0) ? LAST_IDX : tail_reg - IW'(1);
    assign is_full  = (cnt_reg == FULL_CNT);
    assign cnt_zero = (cnt_reg == '0);
    assign is_push  = (item_reg.mode == cdq_pkg::MODE_PUSH_BACK) ||
                      (item_reg.mode == cdq_pkg::MODE_PUSH_FRONT);
    assign reject   = is_push ? is_full : cnt_zero;
    assign stat     = reject ? (is_push ? cdq_pkg::STAT_FULL : cdq_pkg::STAT_EMPTY)
                             : cdq_pkg::STAT_DONE;

    assign sts.rd_pend  = !is_push && !cnt_zero;
    assign sts.out_free = !out_valid_reg || m_ready;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_rd_addr = head_reg;
        if (cmd.exec && !reject) begin
            unique case (item_reg.mode)
                cdq_pkg::MODE_PUSH_BACK: begin
                    ram_wr_en = 1'b1;
                    tail_next = tail_up;
                    cnt_next  = cnt_reg + CW'(1);
                end
                cdq_pkg::MODE_PUSH_FRONT: begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = head_dn;
                    head_next   = head_dn;
                    cnt_next    = cnt_reg + CW'(1);
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    ram_rd_en = 1'b1;
                    head_next = head_up;
                    cnt_next  = cnt_reg - CW'(1);
                end
                cdq_pkg::MODE_POP_BACK: begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = tail_dn;
                    tail_next   = tail_dn;
                    cnt_next    = cnt_reg - CW'(1);
                end
                default: ;
            endcase
        end
    end

    // fill level carries the low byte of the count
    assign fill_ext_next = {{cdq_pkg::FILL_W{1'b0}}, cnt_next};
    assign fill_ext_cur  = {{cdq_pkg::FILL_W{1'b0}}, cnt_reg};

    always_comb begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        priority if (cmd.load_rd) begin
            res_next.status     = cdq_pkg::STAT_DONE;
            res_next.pop_value  = ram_rd_data;
            res_next.fill_level = fill_ext_cur[cdq_pkg::FILL_W-1:0];
            out_valid_next      = 1'b1;
        end else if (cmd.exec && !sts.rd_pend) begin
            res_next.status     = stat;
            res_next.pop_value  = '0;
            res_next.fill_level = fill_ext_next[cdq_pkg::FILL_W-1:0];
            out_valid_next      = 1'b1;
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
        res_reg <= res_next;
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (item_reg.push_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = res_reg;

    logic [CW:0] occ_sum;
    logic [CW:0] occ_tail;
    assign occ_sum  = {{(CW + 1 - IW){1'b0}}, head_reg} + {1'b0, cnt_reg};
    assign occ_tail = (occ_sum >= (CW + 1)'(DEPTH)) ? occ_sum - (CW + 1)'(DEPTH) : occ_sum;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("word count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_tail == {{(CW + 1 - IW){1'b0}}, tail_reg})
        else $error("head, tail and count disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && reject |=> $stable(head_reg) && $stable(tail_reg) && $stable(cnt_reg))
        else $error("rejected request changed the queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && sts.rd_pend |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("pop did not drop the count by one");

endmodule
